// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared constants, codes and structs of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_FRAMES  = 65536;
  localparam int WORD_BITS   = 32;
  localparam int WORDS       = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int CFG_W       = FRAME_W + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WORD_IDX_W  = $clog2(WORDS);
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int GRAN_MASK   = 8;

  localparam logic [CFG_W-1:0] INSTALLED_RESET = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RESERVED_RESET  = CFG_W'(2048);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_MARK    = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INSTALLED = 1'd0,
    REG_RESERVED  = 1'd1
  } reg_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 lo_en;
    logic [BIT_W-1:0]     lo_bit;
    logic                 hi_en;
    logic [BIT_W-1:0]     hi_bit;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_rsp_t;

endpackage

// ===== rtl/pfa_req_if.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator request channel
// Valid/ready channel carrying the mode and frame index of one request.
// ----------------------------------------------------------------------------
interface pfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::MODE_W-1:0]  mode;
  logic [pfa_pkg::FRAME_W-1:0] frame_index;

  modport source (output valid, output mode, output frame_index, input ready);
  modport sink (input valid, input mode, input frame_index, output ready);
endinterface

// ===== rtl/pfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator response channel
// Valid/ready channel carrying the status and granted frame of one request.
// ----------------------------------------------------------------------------
interface pfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pfa_pkg::STATUS_W-1:0] status;
  logic [pfa_pkg::FRAME_W-1:0]  granted_frame;

  modport source (output valid, output status, output granted_frame, input ready);
  modport sink (input valid, input status, input granted_frame, output ready);
endinterface

// ===== rtl/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/pfa_word_scan.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator word scan unit
// Masks frames outside the usable range and finds the lowest free bit.
// ----------------------------------------------------------------------------
module pfa_word_scan (
  input  pfa_pkg::scan_req_t scan_i,
  output pfa_pkg::scan_rsp_t scan_o
);

  localparam logic [pfa_pkg::WORD_BITS-1:0] ONE = pfa_pkg::WORD_BITS'(1);

  logic [pfa_pkg::WORD_BITS-1:0] lo_mask;
  logic [pfa_pkg::WORD_BITS-1:0] hi_mask;
  logic [pfa_pkg::WORD_BITS-1:0] masked;

  always_comb begin
    lo_mask = scan_i.lo_en ? ((ONE << scan_i.lo_bit) - ONE) : '0;
    hi_mask = scan_i.hi_en ? ~((ONE << scan_i.hi_bit) - ONE) : '0;
    masked  = scan_i.word | lo_mask | hi_mask;
    scan_o.found   = ~&masked;
    scan_o.bit_idx = '0;
    for (int i = pfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        scan_o.bit_idx = pfa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/page_frame_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Page frame bitmap allocator core
// Keeps one usage bit per page frame and serves allocate, release and mark
// requests, one at a time.
// ----------------------------------------------------------------------------
// The request channel carries a mode and a frame index; the response channel
// returns a status and the granted frame, one response per request.
// Allocate walks the bitmap one 32-bit word per cycle through the word scan
// unit, starting at the word that holds the first unreserved frame and
// reading at most 2048 words. Release and mark read the word and write it
// back in ST_MODIFY. Requests outside the usable range go straight to ST_RESP.
// The configuration port sets the installed and reserved frame counts; the
// user must write it only while no request is in flight, and the block
// itself does not enforce this. After reset the block clears all 2048 words
// of the bitmap RAM one word per cycle and accepts no request meanwhile.
// A finished response sits in an output register; the next request is taken
// while it waits, and that request's response is held back until the
// receiver has taken the previous one.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_data_i,
  pfa_req_if.sink                       req_i,
  pfa_rsp_if.source                     rsp_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY,
    ST_RESP
  } state_e;

  localparam int WB  = pfa_pkg::BIT_W;
  localparam int FW  = pfa_pkg::FRAME_W;
  localparam int CW  = pfa_pkg::CFG_W;
  localparam int WIW = pfa_pkg::WORD_IDX_W;
  localparam int WDB = pfa_pkg::WORD_BITS;

  state_e                   state_q, state_d;
  logic [WIW-1:0]           clr_q, clr_d;
  logic [WIW-1:0]           word_q, word_d;
  logic [WB-1:0]            bit_q, bit_d;
  logic                     mark_q, mark_d;
  logic [FW-1:0]            res_frame_q, res_frame_d;
  pfa_pkg::status_e         res_status_q, res_status_d;
  logic [CW-1:0]            installed_q, installed_d;
  logic [CW-1:0]            reserved_q, reserved_d;
  logic                     out_valid_q, out_valid_d;
  logic [FW-1:0]            out_frame_q, out_frame_d;
  pfa_pkg::status_e         out_status_q, out_status_d;

  logic [CW-1:0]            inst_round;
  logic [CW-1:0]            lim;
  logic [CW-1:0]            lim_m1;
  logic [WIW-1:0]           last_word;
  logic [CW-WB-1:0]         lim_word;
  logic [CW-1:0]            req_frame;
  logic                     in_range;
  logic                     accept;
  logic                     ram_we;
  logic [WIW-1:0]           ram_waddr;
  logic [WDB-1:0]           ram_wdata;
  logic [WDB-1:0]           ram_rdata;
  logic [WDB-1:0]           bit_mask;
  pfa_pkg::scan_req_t       scan_req;
  pfa_pkg::scan_rsp_t       scan_rsp;

  always_comb begin
    inst_round = installed_q & ~CW'(pfa_pkg::GRAN_MASK - 1);
    lim        = (inst_round > CW'(pfa_pkg::MAX_FRAMES)) ? CW'(pfa_pkg::MAX_FRAMES)
                                                           : inst_round;
    lim_m1     = lim - CW'(1);
    last_word  = lim_m1[FW-1:WB];
    lim_word   = lim[CW-1:WB];
    req_frame  = {1'b0, req_i.frame_index};
    in_range   = (req_frame >= reserved_q) && (req_frame < lim);
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    scan_req.word   = ram_rdata;
    scan_req.lo_en  = (word_q == reserved_q[FW-1:WB]);
    scan_req.lo_bit = reserved_q[WB-1:0];
    scan_req.hi_en  = ({1'b0, word_q} == lim_word);
    scan_req.hi_bit = lim[WB-1:0];
  end

  pfa_word_scan u_scan (
    .scan_i (scan_req),
    .scan_o (scan_rsp)
  );

  always_comb begin
    installed_d = installed_q;
    reserved_d  = reserved_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfa_pkg::REG_INSTALLED: installed_d = cfg_data_i;
        pfa_pkg::REG_RESERVED:  reserved_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    word_d       = word_q;
    bit_d        = bit_q;
    mark_d       = mark_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_frame_d  = out_frame_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = word_q;
    bit_mask     = WDB'(1) << bit_q;
    ram_wdata    = mark_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + WIW'(1);
        if (clr_q == WIW'(pfa_pkg::WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_frame_d  = '0;
          res_status_d = pfa_pkg::STATUS_RANGE;
          state_d      = ST_RESP;
          mark_d       = (req_i.mode == pfa_pkg::MODE_MARK);
          case (req_i.mode) inside
            pfa_pkg::MODE_ALLOC: begin
              if (reserved_q < lim) begin
                word_d  = reserved_q[FW-1:WB];
                state_d = ST_SCAN;
              end else begin
                res_status_d = pfa_pkg::STATUS_NO_FREE;
              end
            end
            pfa_pkg::MODE_RELEASE, pfa_pkg::MODE_MARK: begin
              if (in_range) begin
                word_d      = req_i.frame_index[FW-1:WB];
                bit_d       = req_i.frame_index[WB-1:0];
                res_frame_d = req_i.frame_index;
                state_d     = ST_MODIFY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.found) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata | (WDB'(1) << scan_rsp.bit_idx);
          res_frame_d  = {word_q, scan_rsp.bit_idx};
          res_status_d = pfa_pkg::STATUS_OK;
          state_d      = ST_RESP;
        end else if (word_q == last_word) begin
          res_status_d = pfa_pkg::STATUS_NO_FREE;
          state_d      = ST_RESP;
        end else begin
          word_d = word_q + WIW'(1);
        end
      end
      ST_MODIFY: begin
        ram_we       = 1'b1;
        res_status_d = pfa_pkg::STATUS_OK;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_frame_d  = res_frame_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  pfa_ram #(
    .WIDTH (WDB),
    .DEPTH (pfa_pkg::WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (word_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      installed_q  <= pfa_pkg::INSTALLED_RESET;
      reserved_q   <= pfa_pkg::RESERVED_RESET;
      out_valid_q  <= 1'b0;
      word_q       <= '0;
      bit_q        <= '0;
      mark_q       <= 1'b0;
      res_frame_q  <= '0;
      res_status_q <= pfa_pkg::STATUS_OK;
      out_frame_q  <= '0;
      out_status_q <= pfa_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      installed_q  <= installed_d;
      reserved_q   <= reserved_d;
      out_valid_q  <= out_valid_d;
      word_q       <= word_d;
      bit_q        <= bit_d;
      mark_q       <= mark_d;
      res_frame_q  <= res_frame_d;
      res_status_q <= res_status_d;
      out_frame_q  <= out_frame_d;
      out_status_q <= out_status_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_frame = out_frame_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !ram_we)
    else $error("bitmap written outside a request");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while previous one still in flight");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == pfa_pkg::STATUS_OK) |->
      ({1'b0, rsp_o.granted_frame} >= reserved_q && {1'b0, rsp_o.granted_frame} < lim))
    else $error("granted frame outside usable range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != pfa_pkg::STATUS_OK) |-> (rsp_o.granted_frame == '0))
    else $error("failed request returned nonzero frame");

endmodule
